/* rtl/rsame_pkg.sv */
// ----------------------------------------------------------------------------
// rsame_pkg
// Shared types, register indexes and the microcode table of the RSA
// modular exponentiation core.
// ----------------------------------------------------------------------------
package rsame_pkg;

  // default datapath width and fixed field widths
  localparam int MOD_BITS_DEF = 32;
  localparam int FIELD_W      = 32;
  localparam int EXP_BITS     = 32;
  localparam int ECNT_W       = $clog2(EXP_BITS);

  // configuration register indexes
  localparam logic [1:0] REG_MODULUS          = 2'd0;
  localparam logic [1:0] REG_PUBLIC_EXPONENT  = 2'd1;
  localparam logic [1:0] REG_PRIVATE_EXPONENT = 2'd2;

  // micro program counter
  typedef logic [3:0] upc_t;

  // datapath operations, one per control word
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MSTEP,
    OP_SETB,
    OP_LD_SQ,
    OP_LD_MUL,
    OP_NEXTE,
    OP_EMIT
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_N_ZERO,
    C_CNT_NZ,
    C_EBIT_ZERO,
    C_ECNT_NZ,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    cond_t cond;
    upc_t  target;
    op_t   op;
  } ctrl_word_t;

  // status seen by the sequencer
  typedef struct packed {
    logic no_req;
    logic n_zero;
    logic cnt_nz;
    logic ebit_zero;
    logic ecnt_nz;
    logic out_busy;
  } flags_t;

  // program steps
  localparam upc_t U_WAIT    = 4'd0;
  localparam upc_t U_CHKZ    = 4'd1;
  localparam upc_t U_REDUCE  = 4'd2;
  localparam upc_t U_SETB    = 4'd3;
  localparam upc_t U_LD_SQ   = 4'd4;
  localparam upc_t U_SQUARE  = 4'd5;
  localparam upc_t U_TEST    = 4'd6;
  localparam upc_t U_LD_MUL  = 4'd7;
  localparam upc_t U_MULT    = 4'd8;
  localparam upc_t U_NEXTE   = 4'd9;
  localparam upc_t U_HOLD    = 4'd10;
  localparam upc_t U_EMIT    = 4'd11;

  // microcode rom: jump to target when cond holds, else fall through
  function automatic ctrl_word_t ucode(upc_t pc);
    ctrl_word_t w;
    case (pc)
      U_WAIT:   w = '{cond: C_NO_REQ,    target: U_WAIT,   op: OP_LOAD};
      U_CHKZ:   w = '{cond: C_N_ZERO,    target: U_HOLD,   op: OP_NONE};
      U_REDUCE: w = '{cond: C_CNT_NZ,    target: U_REDUCE, op: OP_MSTEP};
      U_SETB:   w = '{cond: C_NEVER,     target: U_WAIT,   op: OP_SETB};
      U_LD_SQ:  w = '{cond: C_NEVER,     target: U_WAIT,   op: OP_LD_SQ};
      U_SQUARE: w = '{cond: C_CNT_NZ,    target: U_SQUARE, op: OP_MSTEP};
      U_TEST:   w = '{cond: C_EBIT_ZERO, target: U_NEXTE,  op: OP_NONE};
      U_LD_MUL: w = '{cond: C_NEVER,     target: U_WAIT,   op: OP_LD_MUL};
      U_MULT:   w = '{cond: C_CNT_NZ,    target: U_MULT,   op: OP_MSTEP};
      U_NEXTE:  w = '{cond: C_ECNT_NZ,   target: U_LD_SQ,  op: OP_NEXTE};
      U_HOLD:   w = '{cond: C_OUT_BUSY,  target: U_HOLD,   op: OP_NONE};
      U_EMIT:   w = '{cond: C_ALWAYS,    target: U_WAIT,   op: OP_EMIT};
      default:  w = '{cond: C_ALWAYS,    target: U_WAIT,   op: OP_NONE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/rsame_seq.sv */
// ----------------------------------------------------------------------------
// rsame_seq
// Micro sequencer: program counter, control rom and conditional jumps.
// ----------------------------------------------------------------------------
module rsame_seq
  import rsame_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  flags_t     flags,
  output ctrl_word_t ctrl
);

  upc_t pc;
  upc_t pc_next;
  logic take;

  // control word of the current step
  assign ctrl = ucode(pc);

  // jump condition select
  always_comb begin
    case (ctrl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_REQ:    take = flags.no_req;
      C_N_ZERO:    take = flags.n_zero;
      C_CNT_NZ:    take = flags.cnt_nz;
      C_EBIT_ZERO: take = flags.ebit_zero;
      C_ECNT_NZ:   take = flags.ecnt_nz;
      C_OUT_BUSY:  take = flags.out_busy;
      default:     take = 1'b0;
    endcase
    pc_next = take ? ctrl.target : pc + upc_t'(1);
  end

  // program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= U_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* rtl/rsa_modular_exponentiation_core.sv */
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation_core
// value ^ exponent mod modulus by left-to-right square-and-multiply, each
// modular product formed by a bit-serial shift-add-reduce step.
//
//   channel   signals                                   direction
//   in        in_valid/in_ready, func, value            request into core
//   out       out_valid/out_ready, result               request out of core
//   cfg       cfg_valid/cfg_ready, cfg_index, cfg_data  register write into core
//
// A request first reduces value mod modulus, then for each of the 32 exponent
// bits squares and, where the bit is set, multiplies by the reduced value;
// the one shift-add-reduce step forms every product. The core is ready for
// the next request in the same cycle as the result shows.
// A modulus of zero skips the loop and gives 0 through the hold and emit steps.
// Reset clears the sequencer, the output valid and the registers to n=2, e=3,
// d=1; both ready outputs are low during reset. The core takes a new request
// while a result still waits on out, and then stalls at its hold step until
// that result is taken.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation_core
  import rsame_pkg::*;
#(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [FIELD_W-1:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FIELD_W-1:0]  result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [FIELD_W-1:0]  cfg_data
);

  localparam int VB  = (MOD_BITS < FIELD_W) ? MOD_BITS : FIELD_W;
  localparam int CW  = $clog2(MOD_BITS);
  localparam int W2  = MOD_BITS + 2;

  // configuration registers
  logic [FIELD_W-1:0]  modulus;
  logic [FIELD_W-1:0]  public_exponent;
  logic [FIELD_W-1:0]  private_exponent;

  // datapath registers
  logic [MOD_BITS-1:0] n;
  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] mcand;
  logic [MOD_BITS-1:0] opb;
  logic [MOD_BITS-1:0] base;
  logic [EXP_BITS-1:0] expo;
  logic [CW-1:0]       cnt;
  logic [ECNT_W-1:0]   ecnt;
  logic                out_valid_next;

  logic [W2-1:0]       sum;
  logic [W2-1:0]       n1;
  logic [W2-1:0]       n2;
  logic [MOD_BITS-1:0] step;

  ctrl_word_t          ctrl;
  flags_t              flags;
  logic                in_take;

  rsame_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign in_ready  = (ctrl.op == OP_LOAD) && !rst;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = !rst;

  // status to the sequencer
  always_comb begin
    flags.no_req    = !in_valid;
    flags.n_zero    = (n == '0);
    flags.cnt_nz    = (cnt != '0);
    flags.ebit_zero = !expo[EXP_BITS-1];
    flags.ecnt_nz   = (ecnt != '0);
    flags.out_busy  = out_valid;
  end

  // shift-add-reduce: 2*acc + bit*mcand, minus 0, n or 2n
  always_comb begin
    n1  = W2'(n);
    n2  = {1'b0, n, 1'b0};
    sum = {1'b0, acc, 1'b0} + (opb[MOD_BITS-1] ? W2'(mcand) : W2'(0));
    if (sum >= n2) begin
      step = MOD_BITS'(sum - n2);
    end else if (sum >= n1) begin
      step = MOD_BITS'(sum - n1);
    end else begin
      step = sum[MOD_BITS-1:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= FIELD_W'(2);
      public_exponent  <= FIELD_W'(3);
      private_exponent <= FIELD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS:          modulus          <= cfg_data;
        REG_PUBLIC_EXPONENT:  public_exponent  <= cfg_data;
        REG_PRIVATE_EXPONENT: private_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath driven by the control word
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (in_take) begin
          n     <= MOD_BITS'(modulus[VB-1:0]);
          opb   <= MOD_BITS'(value[VB-1:0]);
          expo  <= func ? private_exponent : public_exponent;
          mcand <= MOD_BITS'(1);
          acc   <= '0;
          cnt   <= CW'(MOD_BITS - 1);
        end
      end
      OP_MSTEP: begin
        acc <= step;
        opb <= opb << 1;
        cnt <= cnt - CW'(1);
      end
      OP_SETB: begin
        base <= acc;
        acc  <= (n == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
        ecnt <= ECNT_W'(EXP_BITS - 1);
      end
      OP_LD_SQ: begin
        mcand <= acc;
        opb   <= acc;
        acc   <= '0;
        cnt   <= CW'(MOD_BITS - 1);
      end
      OP_LD_MUL: begin
        mcand <= base;
        opb   <= acc;
        acc   <= '0;
        cnt   <= CW'(MOD_BITS - 1);
      end
      OP_NEXTE: begin
        expo <= expo << 1;
        ecnt <= ecnt - ECNT_W'(1);
      end
      OP_EMIT: begin
        result <= FIELD_W'(acc);
      end
      default: ;
    endcase
  end

  // output slot
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (ctrl.op == OP_EMIT) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/rsame_checker.sv */
// ----------------------------------------------------------------------------
// rsame_checker
// Port-level checks of the RSA exponentiation core, bound to the top level.
// ----------------------------------------------------------------------------
module rsame_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result))
    else $error("result changed while stalled");

  // an accepted request keeps the core busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a result is always below the largest modulus
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result != 32'hFFFF_FFFF)
    else $error("result out of range");

  // a new result appears as the core returns to waiting
  a_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while core busy");

endmodule

bind rsa_modular_exponentiation_core rsame_checker u_rsame_checker (.*);
